@@ hw/rtl/bsp_pkg.sv @@
// Shared widths and latency constants for the box section properties pipeline.
package bsp_pkg;

  // Geometry and fixed-point format
  localparam int unsigned DIM_BITS           = 16;
  localparam int unsigned CENTROID_FRAC_BITS = 8;
  localparam int unsigned IN_W               = 16;

  // Result field widths
  localparam int unsigned AREA_OW  = 32;
  localparam int unsigned CEN_OW   = 24;
  localparam int unsigned MOM_OW   = 63;
  localparam int unsigned SHEAR_OW = 33;

  // Internal datapath widths
  localparam int unsigned SUM_W  = DIM_BITS + 1;
  localparam int unsigned PRD_W  = 2 * DIM_BITS;
  localparam int unsigned PRD2_W = 2 * DIM_BITS + 2;
  localparam int unsigned SHR_W  = 2 * DIM_BITS + 1;
  localparam int unsigned CP_W   = 3 * DIM_BITS;
  localparam int unsigned CUBE_W = 4 * DIM_BITS;
  localparam int unsigned TQ_W   = 4 * DIM_BITS + 2;
  localparam int unsigned TDS_W  = 4 * DIM_BITS + 3;
  localparam int unsigned TDEN_W = 4 * DIM_BITS + 4;
  localparam int unsigned TSPL_W = 2 * DIM_BITS + 1;
  localparam int unsigned TNUM_W = 8 * DIM_BITS + 4;
  localparam int unsigned CNUM_W = 3 * DIM_BITS + CENTROID_FRAC_BITS;
  localparam int unsigned CDEN_W = 2 * DIM_BITS + 1;
  localparam int unsigned MNUM_W = 6 * DIM_BITS;
  localparam int unsigned MSUB_W = 6 * DIM_BITS + 2;
  localparam int unsigned MDEN_W = 2 * DIM_BITS + 4;

  // Divider geometry (one quotient bit per stage)
  localparam int unsigned DIV_NW  = TNUM_W;
  localparam int unsigned DIV_DW  = TDEN_W;
  localparam int unsigned DIV_QW  = MOM_OW;
  localparam int unsigned DIV_LAT = DIV_QW + 1;

  // Pipeline depth
  localparam int unsigned FRONT_STAGES = 8;
  localparam int unsigned PIPE_W       = FRONT_STAGES + DIV_LAT;
  localparam int unsigned LATENCY      = PIPE_W + 1;

endpackage

@@ hw/rtl/bsp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module bsp_div
  import bsp_pkg::*;
(
  input  logic              clk_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o,
  output logic              ovf_o
);

  logic [DIV_DW-1:0] rem_q  [DIV_QW+1];
  logic [DIV_QW-1:0] bits_q [DIV_QW+1];
  logic [DIV_DW-1:0] den_q  [DIV_QW+1];
  logic              ovf_q  [DIV_QW+1];

  // Load: split off the high part and flag a quotient that does not fit
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DIV_DW'(num_i >> DIV_QW);
    bits_q[0] <= num_i[DIV_QW-1:0];
    den_q[0]  <= den_i;
    ovf_q[0]  <= DIV_NW'(num_i >> DIV_QW) >= DIV_NW'(den_i);
  end

  // Step: shift in one numerator bit, subtract if it fits, shift in the quotient bit
  for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
    logic [DIV_DW:0] trial;
    logic            fit;

    assign trial = {rem_q[k-1], bits_q[k-1][DIV_QW-1]};
    assign fit   = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= fit ? DIV_DW'(trial - {1'b0, den_q[k-1]}) : trial[DIV_DW-1:0];
      bits_q[k] <= {bits_q[k-1][DIV_QW-2:0], fit};
      den_q[k]  <= den_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
    end
  end

  assign quo_o = bits_q[DIV_QW];
  assign ovf_o = ovf_q[DIV_QW];

endmodule

@@ hw/rtl/box_section_properties_unit.sv @@
// Top level: rectangular hollow section properties, fully pipelined.
//
//  port group            | dir | handshake
//  ----------------------+-----+-------------------------------------------
//  section (7 x 16 bit)  | in  | taken at a clock edge with start_i high, busy_o low
//  properties (9 fields) | out | done_o high for one cycle per result
//
//  One section enters per clock; every result passes through 8 front
//  stages of products and sums, 64 divider stages and one output
//  register. The divider pipeline sets most of that depth.
//  busy_o stays low: nothing holds the pipeline, results are never stalled.
//  Reset (rst_ni low, asynchronous) clears all valid bits; data registers
//  are not reset.
module box_section_properties_unit
  import bsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [IN_W-1:0]          outer_height_i,
  input  logic [IN_W-1:0]          outer_width_i,
  input  logic [IN_W-1:0]          wall_thickness_i,
  input  logic [IN_W-1:0]          top_thickness_i,
  input  logic [IN_W-1:0]          bottom_thickness_i,
  input  logic [IN_W-1:0]          left_thickness_i,
  input  logic [IN_W-1:0]          right_thickness_i,
  output logic                     done_o,
  output logic                     status_o,
  output logic [AREA_OW-1:0]       net_area_o,
  output logic signed [CEN_OW-1:0] centroid_y_o,
  output logic signed [CEN_OW-1:0] centroid_z_o,
  output logic [MOM_OW-1:0]        inertia_y_o,
  output logic [MOM_OW-1:0]        inertia_z_o,
  output logic [MOM_OW-1:0]        torsion_constant_o,
  output logic [SHEAR_OW-1:0]      shear_area_z_o,
  output logic [SHEAR_OW-1:0]      shear_area_y_o
);

  localparam logic [CEN_OW-1:0] CEN_MAG   = {1'b1, {(CEN_OW-1){1'b0}}};
  localparam logic [63:0]       AREA_MAX  = (64'd1 << AREA_OW) - 64'd1;
  localparam logic [63:0]       SHEAR_MAX = (64'd1 << SHEAR_OW) - 64'd1;

  // Fields that ride beside the dividers
  typedef struct packed {
    logic             bad;
    logic             ny;
    logic             nz;
    logic [PRD_W-1:0] area;
    logic [SHR_W-1:0] shz;
    logic [SHR_W-1:0] shy;
  } side_t;

  logic [PIPE_W-1:0] vld_q;
  logic              done_q;

  // Stage 1
  logic [DIM_BITS-1:0] wall_d, s1_tt_d, s1_tb_d, s1_tl_d, s1_tr_d;
  logic [DIM_BITS-1:0] s1_h_q, s1_b_q, s1_tt_q, s1_tb_q, s1_tl_q, s1_tr_q;
  // Stage 2
  logic [SUM_W-1:0]    st_d, sw_d;
  logic                bad_d, ny_d, nz_d;
  logic [DIM_BITS-1:0] s2_h_q, s2_b_q, s2_hi_q, s2_bi_q, s2_dy_q, s2_dz_q;
  logic [DIM_BITS-1:0] s2_tt_q, s2_tb_q, s2_tl_q, s2_tr_q;
  logic [SUM_W-1:0]    s2_st_q, s2_sw_q, s2_bm2_q, s2_hm2_q;
  logic                s2_bad_q, s2_ny_q, s2_nz_q;
  // Stage 3
  logic [PRD_W-1:0]    s3_aout_q, s3_ain_q, s3_h2_q, s3_b2_q, s3_hi2_q, s3_bi2_q;
  logic [PRD_W-1:0]    s3_tltr_q, s3_tttb_q, s3_dy2_q, s3_dz2_q;
  logic [PRD2_W-1:0]   s3_bm2sq_q, s3_hm2sq_q, s3_bm2st_q, s3_hm2sw_q;
  logic [SHR_W-1:0]    s3_shz_q, s3_shy_q;
  logic [DIM_BITS-1:0] s3_dy_q, s3_dz_q;
  logic                s3_bad_q, s3_ny_q, s3_nz_q;
  // Stage 4
  logic [PRD_W-1:0]    s4_area_q;
  logic [CUBE_W-1:0]   s4_aa_q, s4_oy_q, s4_iy_q, s4_oz_q, s4_iz_q;
  logic [TQ_W-1:0]     s4_tn1_q, s4_tn2_q, s4_td1_q, s4_td2_q;
  logic [CP_W-1:0]     s4_cy_q, s4_cz_q;
  logic [PRD2_W-1:0]   s4_d3y_q, s4_d3z_q;
  logic [SHR_W-1:0]    s4_shz_q, s4_shy_q;
  logic                s4_bad_q, s4_ny_q, s4_nz_q;
  // Stage 5
  logic [PRD_W-1:0]    s5_area_q;
  logic [CUBE_W-1:0]   s5_dify_q, s5_difz_q;
  logic [TDS_W-1:0]    s5_tden_q;
  logic [TQ_W-1:0]     s5_syl_q, s5_syh_q, s5_szl_q, s5_szh_q;
  logic [TQ_W-1:0]     s5_tll_q, s5_tlh_q, s5_thl_q, s5_thh_q;
  logic [CP_W-1:0]     s5_cy_q, s5_cz_q;
  logic [SHR_W-1:0]    s5_shz_q, s5_shy_q;
  logic                s5_bad_q, s5_ny_q, s5_nz_q;
  // Stage 6
  logic [MSUB_W-1:0]   s6_sy_q, s6_sz_q;
  logic [TNUM_W-1:0]   s6_tnum_q;
  logic [TDEN_W-1:0]   s6_tden_q;
  logic [CUBE_W-1:0]   s6_myl_q, s6_myh_q, s6_mzl_q, s6_mzh_q;
  logic [PRD_W-1:0]    s6_area_q;
  logic [CP_W-1:0]     s6_cy_q, s6_cz_q;
  logic [SHR_W-1:0]    s6_shz_q, s6_shy_q;
  logic                s6_bad_q, s6_ny_q, s6_nz_q;
  // Stage 7
  logic [MNUM_W-1:0]   s7_my_q, s7_mz_q;
  logic [MSUB_W-1:0]   s7_sy_q, s7_sz_q;
  logic [TNUM_W-1:0]   s7_tnum_q;
  logic [TDEN_W-1:0]   s7_tden_q;
  logic [PRD_W-1:0]    s7_area_q;
  logic [CP_W-1:0]     s7_cy_q, s7_cz_q;
  logic [SHR_W-1:0]    s7_shz_q, s7_shy_q;
  logic                s7_bad_q, s7_ny_q, s7_nz_q;
  // Stage 8
  logic [MSUB_W:0]     mdy_d, mdz_d;
  logic [MSUB_W-1:0]   s8_mny_q, s8_mnz_q;
  logic [MDEN_W-1:0]   s8_mden_q;
  logic [CDEN_W-1:0]   s8_cden_q;
  logic [CNUM_W-1:0]   s8_cny_q, s8_cnz_q;
  logic [TNUM_W-1:0]   s8_tnum_q;
  logic [TDEN_W-1:0]   s8_tden_q;
  side_t               s8_side_q;
  // Divider side and results
  side_t               side_q [DIV_LAT];
  side_t               side_out;
  logic [DIV_QW-1:0]   q_cy, q_cz, q_my, q_mz, q_tk;
  logic                o_cy, o_cz, o_my, o_mz, o_tk;
  // Output registers
  logic                status_q;
  logic [AREA_OW-1:0]  net_area_q;
  logic [CEN_OW-1:0]   cen_y_q, cen_z_q;
  logic [MOM_OW-1:0]   mom_y_q, mom_z_q, tors_q;
  logic [SHEAR_OW-1:0] sh_z_q, sh_y_q;
  logic [63:0]         area_w, shz_w, shy_w;

  // Map a centroid quotient to a saturated signed code
  function automatic logic [CEN_OW-1:0] cen_code(logic [DIV_QW-1:0] q, logic ovf, logic neg);
    logic             big;
    logic [CEN_OW-1:0] mag;
    big = ovf || (q >= DIV_QW'(CEN_MAG));
    mag = big ? CEN_MAG : CEN_OW'(q);
    if (neg) begin
      cen_code = CEN_OW'(0) - mag;
    end else if (big) begin
      cen_code = CEN_MAG - CEN_OW'(1);
    end else begin
      cen_code = mag;
    end
  endfunction

  // Never hold off a transaction
  assign busy_o = 1'b0;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[PIPE_W-2:0], start_i && !busy_o};
      done_q <= vld_q[PIPE_W-1];
    end
  end

  // Stage 1: pick effective thicknesses
  always_comb begin
    wall_d  = DIM_BITS'(wall_thickness_i);
    s1_tt_d = (DIM_BITS'(top_thickness_i) != '0) ? DIM_BITS'(top_thickness_i) : wall_d;
    s1_tb_d = (DIM_BITS'(bottom_thickness_i) != '0) ? DIM_BITS'(bottom_thickness_i) : wall_d;
    s1_tl_d = (DIM_BITS'(left_thickness_i) != '0) ? DIM_BITS'(left_thickness_i) : wall_d;
    s1_tr_d = (DIM_BITS'(right_thickness_i) != '0) ? DIM_BITS'(right_thickness_i) : wall_d;
  end

  always_ff @(posedge clk_i) begin
    s1_h_q  <= DIM_BITS'(outer_height_i);
    s1_b_q  <= DIM_BITS'(outer_width_i);
    s1_tt_q <= s1_tt_d;
    s1_tb_q <= s1_tb_d;
    s1_tl_q <= s1_tl_d;
    s1_tr_q <= s1_tr_d;
  end

  // Stage 2: sums, inner sizes, mid-line sizes, thickness differences, checks
  always_comb begin
    st_d  = SUM_W'(s1_tt_q) + SUM_W'(s1_tb_q);
    sw_d  = SUM_W'(s1_tl_q) + SUM_W'(s1_tr_q);
    bad_d = (s1_tt_q == '0) || (s1_tb_q == '0) || (s1_tl_q == '0) || (s1_tr_q == '0) ||
            (st_d > SUM_W'(s1_h_q)) || (sw_d > SUM_W'(s1_b_q));
    ny_d  = s1_tl_q > s1_tr_q;
    nz_d  = s1_tb_q > s1_tt_q;
  end

  always_ff @(posedge clk_i) begin
    s2_h_q   <= s1_h_q;
    s2_b_q   <= s1_b_q;
    s2_hi_q  <= DIM_BITS'(SUM_W'(s1_h_q) - st_d);
    s2_bi_q  <= DIM_BITS'(SUM_W'(s1_b_q) - sw_d);
    s2_st_q  <= st_d;
    s2_sw_q  <= sw_d;
    s2_bm2_q <= {s1_b_q, 1'b0} - sw_d;
    s2_hm2_q <= {s1_h_q, 1'b0} - st_d;
    s2_dy_q  <= ny_d ? (s1_tl_q - s1_tr_q) : (s1_tr_q - s1_tl_q);
    s2_dz_q  <= nz_d ? (s1_tb_q - s1_tt_q) : (s1_tt_q - s1_tb_q);
    s2_ny_q  <= ny_d;
    s2_nz_q  <= nz_d;
    s2_bad_q <= bad_d;
    s2_tt_q  <= s1_tt_q;
    s2_tb_q  <= s1_tb_q;
    s2_tl_q  <= s1_tl_q;
    s2_tr_q  <= s1_tr_q;
  end

  // Stage 3: first products
  always_ff @(posedge clk_i) begin
    s3_aout_q  <= PRD_W'(s2_h_q) * PRD_W'(s2_b_q);
    s3_ain_q   <= PRD_W'(s2_hi_q) * PRD_W'(s2_bi_q);
    s3_h2_q    <= PRD_W'(s2_h_q) * PRD_W'(s2_h_q);
    s3_b2_q    <= PRD_W'(s2_b_q) * PRD_W'(s2_b_q);
    s3_hi2_q   <= PRD_W'(s2_hi_q) * PRD_W'(s2_hi_q);
    s3_bi2_q   <= PRD_W'(s2_bi_q) * PRD_W'(s2_bi_q);
    s3_tltr_q  <= PRD_W'(s2_tl_q) * PRD_W'(s2_tr_q);
    s3_tttb_q  <= PRD_W'(s2_tt_q) * PRD_W'(s2_tb_q);
    s3_dy2_q   <= PRD_W'(s2_dy_q) * PRD_W'(s2_dy_q);
    s3_dz2_q   <= PRD_W'(s2_dz_q) * PRD_W'(s2_dz_q);
    s3_bm2sq_q <= PRD2_W'(s2_bm2_q) * PRD2_W'(s2_bm2_q);
    s3_hm2sq_q <= PRD2_W'(s2_hm2_q) * PRD2_W'(s2_hm2_q);
    s3_bm2st_q <= PRD2_W'(s2_bm2_q) * PRD2_W'(s2_st_q);
    s3_hm2sw_q <= PRD2_W'(s2_hm2_q) * PRD2_W'(s2_sw_q);
    s3_shz_q   <= SHR_W'(s2_hi_q) * SHR_W'(s2_sw_q);
    s3_shy_q   <= SHR_W'(s2_bi_q) * SHR_W'(s2_st_q);
    s3_dy_q    <= s2_dy_q;
    s3_dz_q    <= s2_dz_q;
    s3_ny_q    <= s2_ny_q;
    s3_nz_q    <= s2_nz_q;
    s3_bad_q   <= s2_bad_q;
  end

  // Stage 4: area and second products
  always_ff @(posedge clk_i) begin
    s4_area_q <= s3_aout_q - s3_ain_q;
    s4_aa_q   <= CUBE_W'(s3_ain_q) * CUBE_W'(s3_aout_q);
    s4_oy_q   <= CUBE_W'(s3_aout_q) * CUBE_W'(s3_h2_q);
    s4_iy_q   <= CUBE_W'(s3_ain_q) * CUBE_W'(s3_hi2_q);
    s4_oz_q   <= CUBE_W'(s3_aout_q) * CUBE_W'(s3_b2_q);
    s4_iz_q   <= CUBE_W'(s3_ain_q) * CUBE_W'(s3_bi2_q);
    s4_tn1_q  <= TQ_W'(s3_bm2sq_q) * TQ_W'(s3_tltr_q);
    s4_tn2_q  <= TQ_W'(s3_hm2sq_q) * TQ_W'(s3_tttb_q);
    s4_td1_q  <= TQ_W'(s3_bm2st_q) * TQ_W'(s3_tltr_q);
    s4_td2_q  <= TQ_W'(s3_hm2sw_q) * TQ_W'(s3_tttb_q);
    s4_cy_q   <= CP_W'(s3_ain_q) * CP_W'(s3_dy_q);
    s4_cz_q   <= CP_W'(s3_ain_q) * CP_W'(s3_dz_q);
    s4_d3y_q  <= (PRD2_W'(s3_dy2_q) << 1) + PRD2_W'(s3_dy2_q);
    s4_d3z_q  <= (PRD2_W'(s3_dz2_q) << 1) + PRD2_W'(s3_dz2_q);
    s4_shz_q  <= s3_shz_q;
    s4_shy_q  <= s3_shy_q;
    s4_ny_q   <= s3_ny_q;
    s4_nz_q   <= s3_nz_q;
    s4_bad_q  <= s3_bad_q;
  end

  // Stage 5: moment differences, torsion denominator, split partial products
  always_ff @(posedge clk_i) begin
    s5_bad_q  <= s4_bad_q || (s4_area_q == '0);
    s5_area_q <= s4_area_q;
    s5_dify_q <= s4_oy_q - s4_iy_q;
    s5_difz_q <= s4_oz_q - s4_iz_q;
    s5_tden_q <= TDS_W'(s4_td1_q) + TDS_W'(s4_td2_q);
    s5_syl_q  <= TQ_W'(s4_aa_q[PRD_W-1:0]) * TQ_W'(s4_d3z_q);
    s5_syh_q  <= TQ_W'(s4_aa_q[CUBE_W-1:PRD_W]) * TQ_W'(s4_d3z_q);
    s5_szl_q  <= TQ_W'(s4_aa_q[PRD_W-1:0]) * TQ_W'(s4_d3y_q);
    s5_szh_q  <= TQ_W'(s4_aa_q[CUBE_W-1:PRD_W]) * TQ_W'(s4_d3y_q);
    s5_tll_q  <= TQ_W'(s4_tn1_q[TSPL_W-1:0]) * TQ_W'(s4_tn2_q[TSPL_W-1:0]);
    s5_tlh_q  <= TQ_W'(s4_tn1_q[TSPL_W-1:0]) * TQ_W'(s4_tn2_q[TQ_W-1:TSPL_W]);
    s5_thl_q  <= TQ_W'(s4_tn1_q[TQ_W-1:TSPL_W]) * TQ_W'(s4_tn2_q[TSPL_W-1:0]);
    s5_thh_q  <= TQ_W'(s4_tn1_q[TQ_W-1:TSPL_W]) * TQ_W'(s4_tn2_q[TQ_W-1:TSPL_W]);
    s5_cy_q   <= s4_cy_q;
    s5_cz_q   <= s4_cz_q;
    s5_shz_q  <= s4_shz_q;
    s5_shy_q  <= s4_shy_q;
    s5_ny_q   <= s4_ny_q;
    s5_nz_q   <= s4_nz_q;
  end

  // Stage 6: combine partials, split moment numerator products
  always_ff @(posedge clk_i) begin
    s6_sy_q   <= (MSUB_W'(s5_syh_q) << PRD_W) + MSUB_W'(s5_syl_q);
    s6_sz_q   <= (MSUB_W'(s5_szh_q) << PRD_W) + MSUB_W'(s5_szl_q);
    s6_tnum_q <= (TNUM_W'(s5_thh_q) << (2 * TSPL_W)) +
                 ((TNUM_W'(s5_thl_q) + TNUM_W'(s5_tlh_q)) << TSPL_W) + TNUM_W'(s5_tll_q);
    s6_tden_q <= TDEN_W'(s5_tden_q) << 1;
    s6_myl_q  <= CUBE_W'(s5_dify_q[PRD_W-1:0]) * CUBE_W'(s5_area_q);
    s6_myh_q  <= CUBE_W'(s5_dify_q[CUBE_W-1:PRD_W]) * CUBE_W'(s5_area_q);
    s6_mzl_q  <= CUBE_W'(s5_difz_q[PRD_W-1:0]) * CUBE_W'(s5_area_q);
    s6_mzh_q  <= CUBE_W'(s5_difz_q[CUBE_W-1:PRD_W]) * CUBE_W'(s5_area_q);
    s6_area_q <= s5_area_q;
    s6_cy_q   <= s5_cy_q;
    s6_cz_q   <= s5_cz_q;
    s6_shz_q  <= s5_shz_q;
    s6_shy_q  <= s5_shy_q;
    s6_ny_q   <= s5_ny_q;
    s6_nz_q   <= s5_nz_q;
    s6_bad_q  <= s5_bad_q;
  end

  // Stage 7: combine moment numerators
  always_ff @(posedge clk_i) begin
    s7_my_q   <= (MNUM_W'(s6_myh_q) << PRD_W) + MNUM_W'(s6_myl_q);
    s7_mz_q   <= (MNUM_W'(s6_mzh_q) << PRD_W) + MNUM_W'(s6_mzl_q);
    s7_sy_q   <= s6_sy_q;
    s7_sz_q   <= s6_sz_q;
    s7_tnum_q <= s6_tnum_q;
    s7_tden_q <= s6_tden_q;
    s7_area_q <= s6_area_q;
    s7_cy_q   <= s6_cy_q;
    s7_cz_q   <= s6_cz_q;
    s7_shz_q  <= s6_shz_q;
    s7_shy_q  <= s6_shy_q;
    s7_ny_q   <= s6_ny_q;
    s7_nz_q   <= s6_nz_q;
    s7_bad_q  <= s6_bad_q;
  end

  // Stage 8: parallel-axis correction (clamp at zero) and divider operands
  always_comb begin
    mdy_d = {1'b0, MSUB_W'(s7_my_q)} - {1'b0, s7_sy_q};
    mdz_d = {1'b0, MSUB_W'(s7_mz_q)} - {1'b0, s7_sz_q};
  end

  always_ff @(posedge clk_i) begin
    s8_mny_q       <= mdy_d[MSUB_W] ? '0 : mdy_d[MSUB_W-1:0];
    s8_mnz_q       <= mdz_d[MSUB_W] ? '0 : mdz_d[MSUB_W-1:0];
    s8_mden_q      <= (MDEN_W'(s7_area_q) << 3) + (MDEN_W'(s7_area_q) << 2);
    s8_cden_q      <= CDEN_W'(s7_area_q) << 1;
    s8_cny_q       <= CNUM_W'(s7_cy_q) << CENTROID_FRAC_BITS;
    s8_cnz_q       <= CNUM_W'(s7_cz_q) << CENTROID_FRAC_BITS;
    s8_tnum_q      <= s7_tnum_q;
    s8_tden_q      <= s7_tden_q;
    s8_side_q.bad  <= s7_bad_q;
    s8_side_q.ny   <= s7_ny_q;
    s8_side_q.nz   <= s7_nz_q;
    s8_side_q.area <= s7_area_q;
    s8_side_q.shz  <= s7_shz_q;
    s8_side_q.shy  <= s7_shy_q;
  end

  // Dividers: centroids, moments, torsion constant
  bsp_div u_div_cy (
    .clk_i (clk_i),
    .num_i (DIV_NW'(s8_cny_q)),
    .den_i (DIV_DW'(s8_cden_q)),
    .quo_o (q_cy),
    .ovf_o (o_cy)
  );

  bsp_div u_div_cz (
    .clk_i (clk_i),
    .num_i (DIV_NW'(s8_cnz_q)),
    .den_i (DIV_DW'(s8_cden_q)),
    .quo_o (q_cz),
    .ovf_o (o_cz)
  );

  bsp_div u_div_my (
    .clk_i (clk_i),
    .num_i (DIV_NW'(s8_mny_q)),
    .den_i (DIV_DW'(s8_mden_q)),
    .quo_o (q_my),
    .ovf_o (o_my)
  );

  bsp_div u_div_mz (
    .clk_i (clk_i),
    .num_i (DIV_NW'(s8_mnz_q)),
    .den_i (DIV_DW'(s8_mden_q)),
    .quo_o (q_mz),
    .ovf_o (o_mz)
  );

  bsp_div u_div_tk (
    .clk_i (clk_i),
    .num_i (DIV_NW'(s8_tnum_q)),
    .den_i (DIV_DW'(s8_tden_q)),
    .quo_o (q_tk),
    .ovf_o (o_tk)
  );

  // Delay side fields to match the dividers
  always_ff @(posedge clk_i) begin
    side_q[0] <= s8_side_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign side_out = side_q[DIV_LAT-1];
  assign area_w   = 64'(side_out.area);
  assign shz_w    = 64'(side_out.shz);
  assign shy_w    = 64'(side_out.shy);

  // Output register: saturate, format, zero on bad geometry
  always_ff @(posedge clk_i) begin
    status_q <= side_out.bad;
    if (side_out.bad) begin
      net_area_q <= '0;
      cen_y_q    <= '0;
      cen_z_q    <= '0;
      mom_y_q    <= '0;
      mom_z_q    <= '0;
      tors_q     <= '0;
      sh_z_q     <= '0;
      sh_y_q     <= '0;
    end else begin
      net_area_q <= (area_w > AREA_MAX) ? '1 : AREA_OW'(area_w);
      cen_y_q    <= cen_code(q_cy, o_cy, side_out.ny);
      cen_z_q    <= cen_code(q_cz, o_cz, side_out.nz);
      mom_y_q    <= o_my ? '1 : MOM_OW'(q_my);
      mom_z_q    <= o_mz ? '1 : MOM_OW'(q_mz);
      tors_q     <= o_tk ? '1 : MOM_OW'(q_tk);
      sh_z_q     <= (shz_w > SHEAR_MAX) ? '1 : SHEAR_OW'(shz_w);
      sh_y_q     <= (shy_w > SHEAR_MAX) ? '1 : SHEAR_OW'(shy_w);
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign net_area_o         = net_area_q;
  assign centroid_y_o       = $signed(cen_y_q);
  assign centroid_z_o       = $signed(cen_z_q);
  assign inertia_y_o        = mom_y_q;
  assign inertia_z_o        = mom_z_q;
  assign torsion_constant_o = tors_q;
  assign shear_area_z_o     = sh_z_q;
  assign shear_area_y_o     = sh_y_q;

  // Every result traces back to a transaction a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without a matching transaction");

  // Bad geometry gives all-zero results
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> (net_area_o == '0) && (centroid_y_o == '0) &&
      (centroid_z_o == '0) && (inertia_y_o == '0) && (inertia_z_o == '0) &&
      (torsion_constant_o == '0) && (shear_area_z_o == '0) && (shear_area_y_o == '0))
    else $error("nonzero result with error status");

  // Good geometry always has a nonzero area
  a_area_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o |-> net_area_o != '0)
    else $error("zero area with good status");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the box section properties unit.
module tb;
  import bsp_pkg::*;

  typedef struct {
    logic [IN_W-1:0] h, b, wall, tt, tb, tl, tr;
  } section_t;

  typedef struct {
    logic                     status;
    logic [AREA_OW-1:0]       area;
    logic [CEN_OW-1:0]        cy, cz;
    logic [MOM_OW-1:0]        iy, iz, tj;
    logic [SHEAR_OW-1:0]      sz, sy;
  } props_t;

  typedef logic [255:0] wide_t;

  localparam wide_t MAX63_W = {193'd0, {63{1'b1}}};
  localparam wide_t MAX33_W = {223'd0, {33{1'b1}}};
  localparam wide_t MAX32_W = {224'd0, {32{1'b1}}};

  // Saturate a wide value at a field limit
  function automatic wide_t clamp(wide_t v, wide_t lim);
    return (v > lim) ? lim : v;
  endfunction

  // Signed fixed-point centroid offset -(ain)*(p-q)/(2*area)
  function automatic logic [CEN_OW-1:0] centroid_code(wide_t ain, wide_t p, wide_t q,
                                                      wide_t area);
    wide_t d, m;
    d = (p > q) ? p - q : q - p;
    m = clamp((ain * d * (wide_t'(1) << CENTROID_FRAC_BITS)) / (2 * area),
              wide_t'(1) << 23);
    if (p > q) return CEN_OW'(-m);
    return CEN_OW'(clamp(m, (wide_t'(1) << 23) - 1));
  endfunction

  // Second moment about the centroidal axis, with the parallel-axis shift
  function automatic logic [MOM_OW-1:0] moment_about(wide_t b, wide_t h, wide_t bi, wide_t hi,
                                                     wide_t p, wide_t q, wide_t ain,
                                                     wide_t aout, wide_t area);
    wide_t d, num, sub;
    d   = (p > q) ? p - q : q - p;
    num = (b * h * h * h - bi * hi * hi * hi) * area;
    sub = 3 * ain * aout * d * d;
    if (num < sub) return '0;
    return MOM_OW'(clamp((num - sub) / (12 * area), MAX63_W));
  endfunction

  // Expected properties of one section
  function automatic props_t section_props(section_t s);
    props_t r;
    wide_t h, b, tt, tb, tl, tr, hi, bi, aout, ain, area, bm2, hm2, num, den;
    r = '{default: '0};
    h  = s.h;
    b  = s.b;
    tt = (s.tt != 0) ? s.tt : s.wall;
    tb = (s.tb != 0) ? s.tb : s.wall;
    tl = (s.tl != 0) ? s.tl : s.wall;
    tr = (s.tr != 0) ? s.tr : s.wall;
    if (tt == 0 || tb == 0 || tl == 0 || tr == 0 || tt + tb > h || tl + tr > b) begin
      r.status = 1'b1;
      return r;
    end
    hi   = h - tt - tb;
    bi   = b - tl - tr;
    aout = b * h;
    ain  = bi * hi;
    area = aout - ain;
    if (area == 0) begin
      r.status = 1'b1;
      return r;
    end
    r.area = AREA_OW'(clamp(area, MAX32_W));
    r.cy   = centroid_code(ain, tl, tr, area);
    r.cz   = centroid_code(ain, tb, tt, area);
    r.iy   = moment_about(b, h, bi, hi, tb, tt, ain, aout, area);
    r.iz   = moment_about(h, b, hi, bi, tl, tr, ain, aout, area);
    // Bredt constant on the wall mid-line, dimensions doubled
    bm2 = 2 * b - tl - tr;
    hm2 = 2 * h - tt - tb;
    num = bm2 * bm2 * tl * tr * hm2 * hm2 * tt * tb;
    den = 2 * (bm2 * (tt + tb) * tl * tr + hm2 * (tl + tr) * tt * tb);
    r.tj = MOM_OW'(clamp(num / den, MAX63_W));
    r.sz = SHEAR_OW'(clamp(hi * (tl + tr), MAX33_W));
    r.sy = SHEAR_OW'(clamp(bi * (tt + tb), MAX33_W));
    return r;
  endfunction

  // Expected property transactions in flight, oldest first
  class props_scoreboard;
    props_t pending[$];
    int     errors;

    function void note_section(section_t s);
      pending.insert(pending.size(), section_props(s));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_props(props_t got);
      props_t want;
      if (pending.size() == 0) begin
        report("unexpected transaction", 64'd1, 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.area !== want.area) report("net_area", got.area, want.area);
      if (got.cy !== want.cy) report("centroid_y", got.cy, want.cy);
      if (got.cz !== want.cz) report("centroid_z", got.cz, want.cz);
      if (got.iy !== want.iy) report("inertia_y", got.iy, want.iy);
      if (got.iz !== want.iz) report("inertia_z", got.iz, want.iz);
      if (got.tj !== want.tj) report("torsion_constant", got.tj, want.tj);
      if (got.sz !== want.sz) report("shear_area_z", got.sz, want.sz);
      if (got.sy !== want.sy) report("shear_area_y", got.sy, want.sy);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, status_o;
  logic [IN_W-1:0] outer_height_i = '0, outer_width_i = '0, wall_thickness_i = '0;
  logic [IN_W-1:0] top_thickness_i = '0, bottom_thickness_i = '0;
  logic [IN_W-1:0] left_thickness_i = '0, right_thickness_i = '0;
  logic [AREA_OW-1:0]       net_area_o;
  logic signed [CEN_OW-1:0] centroid_y_o, centroid_z_o;
  logic [MOM_OW-1:0]        inertia_y_o, inertia_z_o, torsion_constant_o;
  logic [SHEAR_OW-1:0]      shear_area_z_o, shear_area_y_o;

  props_scoreboard sb = new();
  int idle_pct = 0;

  box_section_properties_unit DUT (.*);

  always #6 clk_i = ~clk_i;

  // Note accepted sections and check strobed results on the same edge
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note_section('{outer_height_i, outer_width_i, wall_thickness_i, top_thickness_i,
                        bottom_thickness_i, left_thickness_i, right_thickness_i});
    if (rst_ni && done_o)
      sb.check_props('{status_o, net_area_o, centroid_y_o, centroid_z_o, inertia_y_o,
                       inertia_z_o, torsion_constant_o, shear_area_z_o, shear_area_y_o});
  end

  // Drive one section and hold it until accepted
  task send_section(section_t s);
    logic ok;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i            <= 1'b1;
    outer_height_i     <= s.h;
    outer_width_i      <= s.b;
    wall_thickness_i   <= s.wall;
    top_thickness_i    <= s.tt;
    bottom_thickness_i <= s.tb;
    left_thickness_i   <= s.tl;
    right_thickness_i  <= s.tr;
    do begin
      @(negedge clk_i);
      ok = !busy_o;
      @(posedge clk_i);
    end while (!ok);
  endtask

  // Random dimension of random magnitude
  function automatic logic [IN_W-1:0] rand_dim();
    return IN_W'($urandom) >> $urandom_range(IN_W);
  endfunction

  // Mostly well-formed sections; some side thicknesses fall back to the wall
  function automatic section_t rand_section();
    section_t s;
    int unsigned sel;
    sel = $urandom_range(99);
    s.h = rand_dim(); s.b = rand_dim(); s.wall = rand_dim();
    s.tt = rand_dim(); s.tb = rand_dim(); s.tl = rand_dim(); s.tr = rand_dim();
    if (sel < 12) return s;
    if (s.h < 2) s.h = IN_W'($urandom_range(2, 65535));
    if (s.b < 2) s.b = IN_W'($urandom_range(2, 65535));
    s.wall = IN_W'($urandom_range(1, s.h < s.b ? s.h / 2 : s.b / 2));
    s.tt = ($urandom_range(4) == 0) ? '0 : IN_W'($urandom_range(1, s.h / 2));
    s.tb = ($urandom_range(4) == 0) ? '0 : IN_W'($urandom_range(1, s.h / 2));
    s.tl = ($urandom_range(4) == 0) ? '0 : IN_W'($urandom_range(1, s.b / 2));
    s.tr = ($urandom_range(4) == 0) ? '0 : IN_W'($urandom_range(1, s.b / 2));
    if (sel < 20 && s.h > 2) s.h = s.h / 2;
    return s;
  endfunction

  task drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    section_t dir[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, fallback to the common wall and invalid geometry
    dir.insert(dir.size(), '{0, 0, 0, 0, 0, 0, 0});
    dir.insert(dir.size(),
               '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    dir.insert(dir.size(), '{16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0});
    dir.insert(dir.size(), '{16'hFFFF, 16'hFFFF, 16'h7FFF, 0, 0, 0, 0});
    dir.insert(dir.size(), '{16'hFFFF, 16'hFFFF, 16'h8000, 0, 0, 0, 0});
    dir.insert(dir.size(), '{100, 60, 5, 0, 0, 0, 0});
    dir.insert(dir.size(), '{100, 60, 0, 5, 5, 5, 0});
    dir.insert(dir.size(), '{100, 60, 0, 3, 9, 2, 7});
    dir.insert(dir.size(), '{100, 60, 4, 50, 50, 0, 0});
    dir.insert(dir.size(), '{100, 60, 4, 0, 0, 30, 30});
    dir.insert(dir.size(), '{100, 60, 4, 51, 50, 0, 0});
    dir.insert(dir.size(), '{100, 60, 4, 0, 0, 31, 30});
    dir.insert(dir.size(), '{2, 2, 1, 0, 0, 0, 0});
    dir.insert(dir.size(), '{16'hFFFF, 16'hFFFF, 1, 1, 16'h7FFF, 1, 16'h7FFF});
    dir.insert(dir.size(), '{16'hFFFF, 16'hFFFF, 1, 16'h7FFF, 1, 16'h7FFF, 1});
    dir.insert(dir.size(), '{16'hFFFF, 3, 1, 0, 0, 0, 0});
    dir.insert(dir.size(), '{3, 16'hFFFF, 1, 0, 0, 0, 0});
    dir.insert(dir.size(),
               '{16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    dir.insert(dir.size(),
               '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    foreach (dir[i]) send_section(dir[i]);
    start_i <= 1'b0;
    drain();

    // Random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 71 : (ph == 3) ? 25 : 0;
      for (int n = 0; n < 450; n++) send_section(rand_section());
      start_i <= 1'b0;
      if (ph == 0) drain();
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
